[design/mlbm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the memory latency and bandwidth model
package mlbm_pkg;

	localparam int TIME_W      = 48;
	localparam int TAG_W       = 16;
	localparam int SIZE_W      = 20;
	localparam int BPC_W       = 20;
	localparam int LAT_W       = 12;
	localparam int FRAC_W      = 8;
	localparam int CNT_OUT_W   = 5;
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
	// ceil numerator: size scaled by the fraction bits plus divisor minus one
	localparam int NUM_W       = SIZE_W + FRAC_W + 1;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CYCLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_LATENCY  = 1'b1;

	localparam logic [BPC_W-1:0] BPC_RESET = 20'd65536;
	localparam logic [LAT_W-1:0] LAT_RESET = 12'd100;

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_RELEASED = 2'd2
	} kind_t;

	typedef struct packed {
		logic              op;
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] request_size;
		logic [TIME_W-1:0] cycle_now;
	} req_t;

	typedef struct packed {
		kind_t                result_kind;
		logic [TAG_W-1:0]     result_tag;
		logic [TIME_W-1:0]    ready_time;
		logic                 last_of_run;
		logic [CNT_OUT_W-1:0] pending_count;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0] ready;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MAX,
		ST_SUM,
		ST_WRITE,
		ST_TREAD,
		ST_TCMP,
		ST_TFLUSH
	} state_t;

endpackage

[design/mlbm_divider.sv]
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module mlbm_divider
	import mlbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [BPC_W-1:0]  divisor,
	output logic              done,
	output logic [NUM_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [BPC_W:0]    rem_q;
	logic [BPC_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [BPC_W:0]    rem_shift;
	logic              fits;

	// next numerator bit shifts into the partial remainder
	assign rem_shift = {rem_q[BPC_W-1:0], num_q[NUM_W-1]};
	assign fits      = rem_shift >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(NUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (step_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? (rem_shift - {1'b0, div_q}) : rem_shift;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[design/mlbm_queue.sv]
`timescale 1ns / 1ps
// ring buffer storage of outstanding requests, one write and one registered read port
module mlbm_queue
	import mlbm_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

[design/memory_latency_bandwidth_model.sv]
`timescale 1ns / 1ps
// top level of the memory latency and bandwidth timing model
//
// a transaction is taken when start is high and busy is low; req carries op, tag,
// request_size and cycle_now. results appear on result for one cycle with
// result_valid high and cannot be held off by the receiver.
// a request (op 0) runs the bit-serial divider for the burst length, one quotient
// bit per step, and three 48-bit add and compare steps; its result is strobed in
// the same cycle as the next transaction can be taken. a request refused because
// the queue is full is answered on the next cycle.
// a tick (op 1) releases entries in turn, reading the head of the queue and then
// comparing its ready time; results trail by one entry so that the final one
// carries last_of_run. at most 16 entries go per tick; a tick with nothing due
// gives no result and holds the block while the head is read and compared, or
// not at all when the queue is empty.
// configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user is to
// make them only while the block is idle, as the block itself does not enforce
// it. reset clears the queue pointers, the count, the bus free time and loads the
// register defaults; the queue storage needs no clearing.
module memory_latency_bandwidth_model
	import mlbm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 result_valid,
	output res_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BPC_W-1:0]     cfg_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t            state_q, state_d;
	logic [BPC_W-1:0]  bpc_q;
	logic [LAT_W-1:0]  lat_q;
	logic [TIME_W-1:0] bus_free_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NRES_W-1:0] nrel_q;
	logic [TAG_W-1:0]  tag_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] start_q;
	res_t              hold_q;
	res_t              res_q;
	logic              res_valid_q;

	logic              accept;
	logic              full;
	logic [BPC_W-1:0]  div_eff;
	logic [NUM_W-1:0]  dividend;
	logic              div_done;
	logic [NUM_W-1:0]  quotient;
	logic [TIME_W-1:0] burst;
	logic [TIME_W-1:0] ready_new;
	entry_t            wr_data;
	entry_t            rd_data;
	logic              due;
	logic              more;
	logic              div_start;
	logic              mem_we;
	logic              emit;
	res_t              emit_val;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign accept    = start && !busy;
	assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign div_eff   = (bpc_q == '0) ? BPC_W'(1) : bpc_q;
	assign dividend  = NUM_W'({req.request_size, {FRAC_W{1'b0}}}) + NUM_W'(div_eff)
		- NUM_W'(1);
	assign burst     = TIME_W'(quotient);
	assign ready_new = bus_free_q + TIME_W'(lat_q);
	assign wr_data   = '{ready: ready_new, tag: tag_q};
	assign due       = rd_data.ready <= now_q;
	// another entry may follow the one just popped
	assign more      = (cnt_q > CNT_W'(1)) && (nrel_q < NRES_W'(MAX_RESULTS - 1));

	mlbm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (div_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	mlbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (tail_q),
		.wr_data (wr_data),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!req.op) begin
						if (!full) state_d = ST_DIV;
					end else if (cnt_q != '0) begin
						state_d = ST_TREAD;
					end
				end
			end
			ST_DIV: if (div_done) state_d = ST_MAX;
			ST_MAX: state_d = ST_SUM;
			ST_SUM: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			ST_TREAD: state_d = ST_TCMP;
			ST_TCMP: begin
				if (due) begin
					state_d = more ? ST_TREAD : ST_TFLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TFLUSH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		mem_we    = 1'b0;
		emit      = 1'b0;
		emit_val  = hold_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !req.op) begin
					if (full) begin
						emit     = 1'b1;
						emit_val = '{result_kind: KIND_REJECTED, result_tag: req.tag,
							ready_time: '0, last_of_run: 1'b1,
							pending_count: CNT_OUT_W'(cnt_q)};
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_WRITE: begin
				mem_we   = 1'b1;
				emit     = 1'b1;
				emit_val = '{result_kind: KIND_ACCEPTED, result_tag: tag_q,
					ready_time: ready_new, last_of_run: 1'b1,
					pending_count: CNT_OUT_W'(cnt_q + CNT_W'(1))};
			end
			ST_TCMP: begin
				// the held completion goes out once the next entry is judged
				if (nrel_q != '0) begin
					emit                 = 1'b1;
					emit_val.last_of_run = !due;
				end
			end
			ST_TFLUSH: begin
				emit                 = 1'b1;
				emit_val.last_of_run = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bpc_q       <= BPC_RESET;
			lat_q       <= LAT_RESET;
			bus_free_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			nrel_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BYTES_PER_CYCLE: bpc_q <= cfg_data;
					CFG_ACCESS_LATENCY:  lat_q <= cfg_data[LAT_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: nrel_q <= '0;
				ST_SUM: bus_free_q <= start_q + burst;
				ST_WRITE: begin
					tail_q <= ptr_inc(tail_q);
					cnt_q  <= cnt_q + CNT_W'(1);
				end
				ST_TCMP: begin
					if (due) begin
						head_q <= ptr_inc(head_q);
						cnt_q  <= cnt_q - CNT_W'(1);
						nrel_q <= nrel_q + NRES_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= req.tag;
			now_q <= req.cycle_now;
		end
		if (state_q == ST_MAX) begin
			start_q <= (now_q > bus_free_q) ? now_q : bus_free_q;
		end
		if (state_q == ST_TCMP && due) begin
			hold_q <= '{result_kind: KIND_RELEASED, result_tag: rd_data.tag,
				ready_time: rd_data.ready, last_of_run: 1'b0,
				pending_count: CNT_OUT_W'(cnt_q - CNT_W'(1))};
		end
		if (emit) begin
			res_q <= emit_val;
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
